// ===== rtl/core/bbpa_pkg.sv =====
// Package for the bitmap block pool allocator.
// Holds status codes, register indexes, map row width and the sequencer states.
// No dependencies.
package bbpa_pkg;

  localparam int ROW_W   = 32;   // used bits held in one map row
  localparam int ROW_BW  = 5;    // bits to select a block within a row
  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 21;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 3;
  localparam int REM_W   = SIZE_W + 1;
  localparam int STEP_W  = 6;    // one quotient bit per step, 64 steps

  localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = SIZE_W'(8);

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ALIGN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTUSED = 3'd4;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLK_BYTES   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_DIV,
    S_FREE_CHK,
    S_FREE_UPD,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/bitmap_block_pool_allocator.sv =====
// Allocate goes straight to the result when full, else it scans map rows, then multiplies and adds.
// Free goes straight to the result when below base, else it divides, checks and updates the map.
// One transaction at a time; the free path uses a 64-step bit-serial divider.
// Reset and every block_count write start a clearing pass over all
// ceil(MAX_BLOCKS/32) rows of the used map, during which no transaction is accepted.
// Uses bbpa_pkg (status codes, states, widths).
module bitmap_block_pool_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [bbpa_pkg::ADDR_W-1:0]     in_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bbpa_pkg::STAT_W-1:0]     out_status,
  output logic [bbpa_pkg::ADDR_W-1:0]     out_block_address,
  output logic [bbpa_pkg::CNT_W-1:0]      out_free_left,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);
  import bbpa_pkg::*;

  localparam int ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ROW_AW + ROW_BW;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_BLOCKS < 8191) ? MAX_BLOCKS : 8191);
  localparam logic [CNT_W-1:0] RST_CNT =
    CNT_W'((MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // configuration
  logic [ADDR_W-1:0] pool_base_r;
  logic [SIZE_W-1:0] blk_bytes_r;
  logic [CNT_W-1:0]  block_count_r;
  logic              cfg_wr;
  logic              cnt_wr;

  // sequencer and datapath
  state_t             state_r, state_nxt;
  logic [ROW_AW-1:0]  clr_row_r;
  logic [ROW_AW-1:0]  scan_row_r;
  logic [CNT_W-1:0]   free_count_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ADDR_W-1:0]  dq_r;
  logic [REM_W-1:0]   rem_r;
  logic [STEP_W-1:0]  step_r;
  logic [STAT_W-1:0]  res_status_r;
  logic [ADDR_W-1:0]  res_addr_r;

  logic [STAT_W-1:0]  out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [CNT_W-1:0]   out_free_r;
  logic               out_valid_r;

  // used map
  logic [ROW_W-1:0]   map_mem [ROWS];
  logic [ROW_W-1:0]   rd_data_r;
  logic [ROW_AW-1:0]  rd_addr;
  logic [ROW_AW-1:0]  wr_addr;
  logic [ROW_W-1:0]   wr_data;
  logic               wr_en;

  logic [SIZE_W-1:0]  eff_size;
  logic [CNT_W-1:0]   eff_count;
  logic               in_acc;
  logic               out_load;
  logic               zero_found;
  logic [ROW_BW-1:0]  zero_bit;
  logic [REM_W-1:0]   div_trial;
  logic               div_ge;
  logic               idx_over;
  logic               bit_used;
  logic [ROW_AW-1:0]  free_row;
  logic [ROW_BW-1:0]  free_bit;

  function automatic logic [ROW_BW-1:0] lowest_zero(input logic [ROW_W-1:0] row);
    logic [ROW_BW-1:0] pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!row[i]) pos = ROW_BW'(i);
    end
    return pos;
  endfunction

  assign eff_size  = (blk_bytes_r < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : blk_bytes_r;
  assign eff_count = (block_count_r > CNT_CAP) ? CNT_CAP : block_count_r;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign cnt_wr = cfg_wr && (paddr[4:3] == REG_BLOCK_COUNT);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:3])
      REG_POOL_BASE:   prdata = pool_base_r;
      REG_BLK_BYTES:   prdata = 64'(blk_bytes_r);
      REG_BLOCK_COUNT: prdata = 64'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      blk_bytes_r   <= MIN_BLOCK_BYTES;
      block_count_r <= CNT_W'(4096);
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_POOL_BASE:   pool_base_r   <= pwdata;
        REG_BLK_BYTES:   blk_bytes_r   <= pwdata[SIZE_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign zero_found = ~&rd_data_r;
  assign zero_bit   = lowest_zero(rd_data_r);

  // one restoring step: shift the next dividend bit into the remainder
  assign div_trial = {rem_r[REM_W-2:0], dq_r[ADDR_W-1]};
  assign div_ge    = div_trial >= REM_W'(eff_size);

  assign idx_over = dq_r >= ADDR_W'(eff_count);
  assign free_row = dq_r[IDX_W-1:ROW_BW];
  assign free_bit = dq_r[ROW_BW-1:0];
  assign bit_used = rd_data_r[free_bit];

  // next state
  always_comb begin
    state_nxt = state_r;
    priority if (cnt_wr) begin
      state_nxt = S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR:     if (clr_row_r == LAST_ROW) state_nxt = S_IDLE;
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_ALLOC) begin
              state_nxt = (free_count_r == '0) ? S_FINISH : S_ALLOC_RD;
            end else begin
              state_nxt = (in_address < pool_base_r) ? S_FINISH : S_DIV;
            end
          end
        end
        S_ALLOC_RD:  state_nxt = S_ALLOC_CHK;
        S_ALLOC_CHK: state_nxt = zero_found ? S_ALLOC_MUL : S_ALLOC_RD;
        S_ALLOC_MUL: state_nxt = S_ALLOC_ADD;
        S_ALLOC_ADD: state_nxt = S_FINISH;
        S_DIV:       if (step_r == '1) state_nxt = S_FREE_CHK;
        S_FREE_CHK:  state_nxt = (idx_over || rem_r != '0) ? S_FINISH : S_FREE_UPD;
        S_FREE_UPD:  state_nxt = S_FINISH;
        S_FINISH:    if (out_load) state_nxt = S_IDLE;
        default:     state_nxt = S_CLEAR;
      endcase
    end
  end

  // sequencer outputs: map port control and input stall
  always_comb begin
    in_stall = (state_r != S_IDLE);
    rd_addr  = scan_row_r;
    wr_en    = 1'b0;
    wr_addr  = clr_row_r;
    wr_data  = '0;
    unique case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_FREE_CHK: rd_addr = free_row;
      S_ALLOC_CHK: begin
        wr_en   = zero_found;
        wr_addr = scan_row_r;
        wr_data = rd_data_r | (ROW_W'(1) << zero_bit);
      end
      S_FREE_UPD: begin
        wr_en   = bit_used;
        wr_addr = free_row;
        wr_data = rd_data_r & ~(ROW_W'(1) << free_bit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_row_r    <= '0;
      free_count_r <= RST_CNT;
    end else begin
      state_r <= state_nxt;
      if (cnt_wr) begin
        clr_row_r    <= '0;
        free_count_r <= (pwdata[CNT_W-1:0] > CNT_CAP) ? CNT_CAP : pwdata[CNT_W-1:0];
      end else begin
        if (state_r == S_CLEAR) clr_row_r <= clr_row_r + ROW_AW'(1);
        if (state_r == S_ALLOC_CHK && zero_found) free_count_r <= free_count_r - CNT_W'(1);
        if (state_r == S_FREE_UPD && bit_used) free_count_r <= free_count_r + CNT_W'(1);
      end
    end
  end

  // datapath: scan row, divider, multiply and add
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        scan_row_r   <= '0;
        step_r       <= '0;
        rem_r        <= '0;
        dq_r         <= in_address - pool_base_r;
        res_addr_r   <= '0;
        res_status_r <= (in_mode == MODE_ALLOC) ? ST_FULL : ST_RANGE;
      end
      S_ALLOC_CHK: begin
        if (zero_found) begin
          idx_r        <= {scan_row_r, zero_bit};
          res_status_r <= ST_OK;
        end else begin
          scan_row_r <= scan_row_r + ROW_AW'(1);
        end
      end
      S_ALLOC_MUL: prod_r <= PROD_W'(idx_r) * PROD_W'(eff_size);
      S_ALLOC_ADD: res_addr_r <= pool_base_r + ADDR_W'(prod_r);
      S_DIV: begin
        step_r <= step_r + STEP_W'(1);
        rem_r  <= div_ge ? (div_trial - REM_W'(eff_size)) : div_trial;
        dq_r   <= {dq_r[ADDR_W-2:0], div_ge};
      end
      S_FREE_CHK: begin
        priority if (idx_over)  res_status_r <= ST_RANGE;
        else if (rem_r != '0)   res_status_r <= ST_ALIGN;
        else                    res_status_r <= ST_NOTUSED;
      end
      S_FREE_UPD: if (bit_used) res_status_r <= ST_OK;
      default: ;
    endcase
  end

  // output register frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_free_r   <= free_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_free_left     = out_free_r;

endmodule
